### hw/rtl/art_pkg.sv
`default_nettype none

package art_pkg;

   // Field widths fixed by the interface.
   localparam int ADDR_FIELD_W = 48;
   localparam int LEN_W        = 40;
   localparam int STATUS_W     = 3;

   // Defaults for the top-level parameters.
   localparam int ENTRIES_DEF   = 64;
   localparam int ADDR_BITS_DEF = 48;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_FIND   = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT      = 3'd0,
      ST_INSIDE   = 3'd1,
      ST_APPENDED = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_NULL     = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan;
      logic shift;
      logic finish;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic direct;
      logic scan_done;
      logic found;
      logic is_remove;
      logic shift_done;
      logic slot_free;
   } ctl_sts_type;

endpackage

`default_nettype wire

### hw/rtl/art_ram.sv
`default_nettype none

module art_ram #(
   parameter int WIDTH = 88,
   parameter int DEPTH = 64,
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [IW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [IW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

### hw/rtl/art_ctrl.sv
`default_nettype none

module art_ctrl
   import art_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire ctl_sts_type sts,
   output ctl_cmd_type      cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.direct ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = (sts.found && sts.is_remove) ? S_SHIFT : S_FINISH;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.shift_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // The result register must be free before the table is updated.
            if (sts.slot_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

### hw/rtl/art_dpath.sv
`default_nettype none

module art_dpath
   import art_pkg::*;
#(
   parameter int ENTRIES   = ENTRIES_DEF,
   parameter int ADDR_BITS = ADDR_BITS_DEF,
   localparam int AW = (ADDR_BITS < ADDR_FIELD_W) ? ADDR_BITS : ADDR_FIELD_W,
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int RW = AW + LEN_W
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ctl_cmd_type             cmd,
   output ctl_sts_type                  sts,
   input  wire logic [1:0]              req_func,
   input  wire logic [ADDR_FIELD_W-1:0] req_addr,
   input  wire logic [LEN_W-1:0]        req_region_size,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic      [STATUS_W-1:0]     rsp_status,
   output logic      [LEN_W-1:0]        rsp_bytes_left,
   output logic                         ram_we,
   output logic      [IW-1:0]           ram_waddr,
   output logic      [RW-1:0]           ram_wdata,
   output logic      [IW-1:0]           ram_raddr,
   input  wire logic [RW-1:0]           ram_rdata
);

   localparam int CW = $clog2(ENTRIES + 1);
   localparam int DW = (AW > LEN_W) ? AW : LEN_W;

   // Request registers.
   logic [1:0]       func_ff;
   logic [AW-1:0]    addr_ff;
   logic [LEN_W-1:0] size_ff;

   // Table occupancy and scan pipeline.
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic [CW-1:0]    rd_idx_ff;
   logic [CW-1:0]    cmp_idx_ff;
   logic             cmp_vld_ff;

   // First matching entry.
   logic             found_ff;
   logic             hit_inside_ff;
   logic [IW-1:0]    hit_idx_ff;
   logic [LEN_W-1:0] hit_len_ff;
   logic [AW-1:0]    hit_diff_ff;

   // Result register.
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [STATUS_W-1:0] rsp_status_in;
   logic [LEN_W-1:0]    rsp_left_ff;
   logic [LEN_W-1:0]    rsp_left_in;

   logic [AW-1:0]    rd_base;
   logic [LEN_W-1:0] rd_len;
   logic [AW-1:0]    diff;
   logic             exact;
   logic             contained;
   logic             match_now;
   logic             issue;
   logic             addr_null;
   logic             table_full;
   logic [CW-1:0]    shift_dst;
   logic             slot_free;

   assign rd_base    = ram_rdata[RW-1:LEN_W];
   assign rd_len     = ram_rdata[LEN_W-1:0];
   assign diff       = addr_ff - rd_base;
   assign exact      = (addr_ff == rd_base);
   assign contained  = (addr_ff > rd_base) && (DW'(diff) < DW'(rd_len));
   assign addr_null  = (addr_ff == '0);
   assign table_full = (count_ff == CW'(ENTRIES));
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   // Remove looks for an equal base only; add and find also take a
   // containing region.
   assign match_now = cmd.scan && cmp_vld_ff &&
                      (exact || ((func_ff != FUNC_REMOVE) && contained));
   assign issue     = (cmd.scan || cmd.shift) && (rd_idx_ff < count_ff);
   assign shift_dst = cmp_idx_ff - CW'(1);
   assign ram_raddr = rd_idx_ff[IW-1:0];

   always_comb begin
      sts            = '0;
      sts.direct     = (req_func == FUNC_CLEAR) || (req_addr[AW-1:0] == '0);
      sts.scan_done  = match_now || (!cmp_vld_ff && !issue);
      sts.found      = match_now;
      sts.is_remove  = (func_ff == FUNC_REMOVE);
      sts.shift_done = !cmp_vld_ff && !issue;
      sts.slot_free  = slot_free;
   end

   // Table write port: shifting entries down during remove, or the
   // update or append of an add.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = shift_dst[IW-1:0];
      ram_wdata = ram_rdata;
      if (cmd.shift && cmp_vld_ff) begin
         ram_we = 1'b1;
      end else if (cmd.finish && (func_ff == FUNC_ADD) && !addr_null) begin
         ram_wdata = {addr_ff, size_ff};
         if (found_ff && !hit_inside_ff) begin
            ram_we    = 1'b1;
            ram_waddr = hit_idx_ff;
         end else if (!found_ff && !table_full) begin
            ram_we    = 1'b1;
            ram_waddr = count_ff[IW-1:0];
         end
      end
   end

   always_comb begin
      count_in      = count_ff;
      rsp_status_in = ST_HIT;
      rsp_left_in   = '0;
      if (func_ff == FUNC_CLEAR) begin
         count_in = '0;
      end else if (addr_null) begin
         rsp_status_in = ST_NULL;
      end else begin
         case (func_ff)
            FUNC_ADD: begin
               if (found_ff && !hit_inside_ff) begin
                  rsp_left_in = size_ff;
               end else if (found_ff) begin
                  rsp_status_in = ST_INSIDE;
                  rsp_left_in   = hit_len_ff;
               end else if (table_full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  count_in      = count_ff + CW'(1);
                  rsp_status_in = ST_APPENDED;
                  rsp_left_in   = size_ff;
               end
            end
            FUNC_FIND: begin
               if (!found_ff) begin
                  rsp_status_in = ST_NOTFOUND;
               end else if (!hit_inside_ff) begin
                  rsp_left_in = hit_len_ff;
               end else begin
                  rsp_status_in = ST_INSIDE;
                  rsp_left_in   = LEN_W'(DW'(hit_len_ff) - DW'(hit_diff_ff));
               end
            end
            FUNC_REMOVE: begin
               if (found_ff) begin
                  count_in = count_ff - CW'(1);
               end else begin
                  rsp_status_in = ST_NOTFOUND;
               end
            end
            default: begin
               rsp_status_in = ST_HIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         addr_ff <= req_addr[AW-1:0];
         size_ff <= req_region_size;
      end
      if (match_now) begin
         hit_idx_ff    <= cmp_idx_ff[IW-1:0];
         hit_inside_ff <= !exact;
         hit_len_ff    <= rd_len;
         hit_diff_ff   <= diff;
      end
      if (cmd.scan || cmd.shift) begin
         cmp_idx_ff <= rd_idx_ff;
      end
      if (cmd.finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_left_ff   <= rsp_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            rd_idx_ff  <= '0;
            cmp_vld_ff <= 1'b0;
            found_ff   <= 1'b0;
         end else if (match_now) begin
            // A remove continues by shifting from the entry after the hit.
            found_ff   <= 1'b1;
            rd_idx_ff  <= cmp_idx_ff + CW'(1);
            cmp_vld_ff <= 1'b0;
         end else if (cmd.scan || cmd.shift) begin
            cmp_vld_ff <= issue;
            if (issue) begin
               rd_idx_ff <= rd_idx_ff + CW'(1);
            end
         end
         if (cmd.finish) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_bytes_left = rsp_left_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("entry count exceeds table depth");

   a_finish_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> !ram_we)
      else $error("table written during a scan");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && (func_ff == FUNC_CLEAR)) |=> (count_ff == '0))
      else $error("clear left entries in the table");

endmodule

`default_nettype wire

### hw/rtl/allocation_region_table.sv
// Allocation region table: holds up to ENTRIES regions (base address and
// 40-bit byte length) in insertion order in a single-port-write,
// registered-read RAM, and serves add, find, remove and clear requests one
// at a time. Add, find and remove scan the stored entries one per cycle
// through the RAM read port, ending early at the first matching entry; a
// successful remove then shifts each later entry down by one, one entry
// per cycle. Clear and requests with a null address skip the scan and go
// straight to writing the result. A new request is taken while the
// previous result still waits in the output register, and that request
// completes once the result has been taken. Addresses use the low
// ADDR_BITS bits of req_addr, at most 48.
`default_nettype none

module allocation_region_table
   import art_pkg::*;
#(
   parameter int ENTRIES   = ENTRIES_DEF,
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_func,
   input  wire logic [ADDR_FIELD_W-1:0] req_addr,
   input  wire logic [LEN_W-1:0]        req_region_size,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic      [STATUS_W-1:0]     rsp_status,
   output logic      [LEN_W-1:0]        rsp_bytes_left
);

   localparam int AW = (ADDR_BITS < ADDR_FIELD_W) ? ADDR_BITS : ADDR_FIELD_W;
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RW = AW + LEN_W;

   ctl_cmd_type   cmd;
   ctl_sts_type   sts;
   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [RW-1:0] ram_wdata;
   logic [IW-1:0] ram_raddr;
   logic [RW-1:0] ram_rdata;

   art_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   art_dpath #(
      .ENTRIES   (ENTRIES),
      .ADDR_BITS (ADDR_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_addr        (req_addr),
      .req_region_size (req_region_size),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_bytes_left  (rsp_bytes_left),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_wdata       (ram_wdata),
      .ram_raddr       (ram_raddr),
      .ram_rdata       (ram_rdata)
   );

   art_ram #(
      .WIDTH (RW),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire
